FILE: sv/mfpt_pkg.sv
// ============================================================================
// mfpt_pkg
// Shared types, constants and fixed-point helpers of the milestone MFPT solver.
// ============================================================================
package mfpt_pkg;

  localparam int MAX_MS     = 64;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int PROB_W     = 17;
  localparam int PROB_FRAC  = 16;
  localparam int TIME_W     = 32;
  localparam int TIME_FRAC  = 16;
  localparam int IFB        = 32;
  localparam int OUT_FRAC   = 24;
  localparam int DATA_W     = 64;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  typedef logic signed [DATA_W-1:0] fix_t;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC;
  localparam fix_t FIX_ONE  = fix_t'(1) <<< IFB;
  localparam fix_t FIX_MONE = -FIX_ONE;
  localparam fix_t FIX_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fix_t FIX_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START   = 1'b0,
    CFG_TWO_WAY = 1'b1
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_FIRST_LEAK = 3'd1,
    ST_LAST_LEAK  = 3'd2,
    ST_ZERO_FLUX  = 3'd3,
    ST_BAD_START  = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PS_I   = 2'd0,
    PS_I1  = 2'd1,
    PS_IM1 = 2'd2
  } psel_t;

  typedef enum logic [2:0] {
    MS_NONE  = 3'd0,
    MS_FP_FM = 3'd1,
    MS_FM_PR = 3'd2,
    MS_FP_X  = 3'd3,
    MS_TM_X  = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    DS_NONE = 2'd0,
    DS_M_PD = 2'd1,
    DS_PR_PD = 2'd2,
    DS_T_DG = 2'd3
  } div_sel_t;

  typedef enum logic [3:0] {
    LD_NONE = 4'd0,
    LD_FP   = 4'd1,
    LD_FM   = 4'd2,
    LD_D    = 4'd3,
    LD_R    = 4'd4,
    LD_X    = 4'd5,
    LD_ACC  = 4'd6,
    LD_T    = 4'd7,
    LD_INC  = 4'd8
  } ld_t;

  typedef struct packed {
    logic     store;
    logic     begin_solve;
    logic     init;
    logic     init_rev;
    psel_t    psel;
    ld_t      ld;
    mul_sel_t mul_sel;
    div_sel_t div_sel;
    logic     save_fwd;
    logic     save_rev;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic code_ok;
    logic n_zero;
    logic n_one;
    logic i_zero;
    logic i_last;
    logic two_way;
    logic mul_done;
    logic div_done;
  } stat_t;

  function automatic logic [DATA_W-1:0] mag(input fix_t v);
    return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
  endfunction

  function automatic fix_t from_mag(input logic [DATA_W-1:0] m, input logic neg);
    fix_t r;
    if (neg) begin
      r = m[DATA_W-1] ? FIX_MIN : -$signed(m);
    end else begin
      r = m[DATA_W-1] ? FIX_MAX : $signed(m);
    end
    return r;
  endfunction

  function automatic fix_t sat_sub(input fix_t a, input fix_t b);
    logic signed [DATA_W:0] d;
    fix_t r;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      r = d[DATA_W] ? FIX_MIN : FIX_MAX;
    end else begin
      r = d[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic fix_t to_out(input fix_t v);
    return from_mag(mag(v) >> (IFB - OUT_FRAC), v[DATA_W-1]);
  endfunction

endpackage

FILE: sv/mfpt_mul.sv
// ============================================================================
// mfpt_mul
// Signed fixed-point multiplier: four 32x32 partial products, one per cycle,
// truncated magnitude and saturation on the last cycle.
// ============================================================================
module mfpt_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  mfpt_pkg::fix_t a,
  input  mfpt_pkg::fix_t b,
  output logic          done,
  output mfpt_pkg::fix_t res
);
  import mfpt_pkg::*;

  logic [DATA_W-1:0]   ua;
  logic [DATA_W-1:0]   ub;
  logic                neg;
  logic [2*DATA_W-1:0] acc;
  logic [1:0]          step;
  logic                busy;
  logic                fin;

  logic [DATA_W/2-1:0] ah;
  logic [DATA_W/2-1:0] bh;
  logic [DATA_W-1:0]   prod;
  logic [2*DATA_W-1:0] pext;
  logic [2*DATA_W-1:0] psh;
  logic [DATA_W-1:0]   mres;

  always_comb begin
    ah   = step[0] ? ua[DATA_W-1:DATA_W/2] : ua[DATA_W/2-1:0];
    bh   = step[1] ? ub[DATA_W-1:DATA_W/2] : ub[DATA_W/2-1:0];
    prod = ah * bh;
    pext = {{DATA_W{1'b0}}, prod};
    unique case (step)
      2'd0:    psh = pext;
      2'd3:    psh = pext << DATA_W;
      default: psh = pext << (DATA_W / 2);
    endcase
    mres = (|acc[2*DATA_W-1:DATA_W+IFB]) ? '1 : acc[DATA_W+IFB-1:IFB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        fin  <= 1'b0;
      end else if (busy) begin
        if (step == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ua   <= mag(a);
      ub   <= mag(b);
      neg  <= a[DATA_W-1] ^ b[DATA_W-1];
      acc  <= '0;
      step <= 2'd0;
    end else if (busy) begin
      acc  <= acc + psh;
      step <= step + 2'd1;
    end
    if (fin) begin
      res <= from_mag(mres, neg);
    end
  end

endmodule

FILE: sv/mfpt_div.sv
// ============================================================================
// mfpt_div
// Signed fixed-point divider: restoring radix-2, one quotient bit per cycle,
// truncated magnitude and saturation on overflow or zero divisor.
// ============================================================================
module mfpt_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  mfpt_pkg::fix_t a,
  input  mfpt_pkg::fix_t b,
  output logic          done,
  output mfpt_pkg::fix_t res
);
  import mfpt_pkg::*;

  localparam int QW = 2 * DATA_W;

  logic [QW-1:0]     num;
  logic [QW-1:0]     quo;
  logic [DATA_W-1:0] den;
  logic [DATA_W-1:0] rem;
  logic              neg;
  logic              a_zero;
  logic [6:0]        cnt;
  logic              busy;
  logic              fin;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] qmag;

  always_comb begin
    rem_sh = {rem, num[QW-1]};
    diff   = rem_sh - {1'b0, den};
    ge     = rem_sh >= {1'b0, den};
    qmag   = (|quo[QW-1:DATA_W]) ? '1 : quo[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        fin  <= 1'b0;
      end else if (busy) begin
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      num    <= {{DATA_W{1'b0}}, mag(a)} << IFB;
      den    <= mag(b);
      neg    <= a[DATA_W-1] ^ b[DATA_W-1];
      a_zero <= (a == '0);
      rem    <= '0;
      quo    <= '0;
      cnt    <= '0;
    end else if (busy) begin
      num <= num << 1;
      quo <= {quo[QW-2:0], ge};
      rem <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      cnt <= cnt + 7'd1;
    end
    if (fin) begin
      // zero numerator gives zero, even over a zero divisor
      res <= a_zero ? '0 : from_mag(qmag, neg);
    end
  end

endmodule

FILE: sv/mfpt_dp.sv
// ============================================================================
// mfpt_dp
// Datapath: milestone stores, chain checks, elimination registers,
// multiplier and divider, result registers.
// ============================================================================
module mfpt_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mfpt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mfpt_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [mfpt_pkg::PROB_W-1:0]           forward_prob,
  input  logic [mfpt_pkg::TIME_W-1:0]           mean_time,
  input  logic                                  last_milestone,
  input  mfpt_pkg::cmd_t                        cmd,
  output mfpt_pkg::stat_t                       stat,
  output mfpt_pkg::fix_t                        forward_mfpt,
  output mfpt_pkg::fix_t                        reverse_mfpt,
  output logic [mfpt_pkg::STAT_W-1:0]           status
);
  import mfpt_pkg::*;

  logic [PROB_W-1:0] prob_mem [MAX_MS];
  logic [TIME_W-1:0] time_mem [MAX_MS];
  fix_t              diag_mem [MAX_MS];
  fix_t              rhs_mem  [MAX_MS];

  logic [PROB_W-1:0] prob_q;
  logic [TIME_W-1:0] time_q;
  fix_t              diag_q;
  fix_t              rhs_q;

  logic [CNT_W-1:0]  count;
  logic              err_ovf;
  logic              first_bad;
  logic              zero_seen;
  logic              last_nz;
  logic [CNT_W-1:0]  start_ms;
  logic              two_way;

  logic [ADDR_W-1:0] i;
  logic              rev;
  fix_t fp, fm, pd, pr, d, x, t, sum, fwd_r, rev_r;

  logic [PROB_W-1:0] p_in;
  status_t           code;
  logic              rev_eff;
  logic [CNT_W-1:0]  sidx;
  logic [ADDR_W-1:0] n_m1;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] paddr;
  logic [ADDR_W-1:0] taddr;
  logic [PROB_W-1:0] pv;
  fix_t              cfp;
  fix_t              tval;
  fix_t              orig_i;
  fix_t              orig_n;
  fix_t              r_new;
  logic              dg_we;
  logic [ADDR_W-1:0] dg_addr;
  fix_t              dg_data;
  fix_t              rh_data;

  fix_t ma, mb, da, db, mres, qres;
  logic mdone, ddone;

  mfpt_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_sel != MS_NONE),
    .a    (ma),
    .b    (mb),
    .done (mdone),
    .res  (mres)
  );

  mfpt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_sel != DS_NONE),
    .a    (da),
    .b    (db),
    .done (ddone),
    .res  (qres)
  );

  function automatic logic [ADDR_W-1:0] chain_addr(input logic r, input logic [ADDR_W-1:0] kk,
                                                    input logic [CNT_W-1:0] nm);
    return r ? (nm[ADDR_W-1:0] - ADDR_W'(1) - kk) : kk;
  endfunction

  always_comb begin
    p_in = (forward_prob > PROB_ONE) ? PROB_ONE : forward_prob;

    priority if (err_ovf)                                   code = ST_OVERFLOW;
    else if (start_ms == '0 || start_ms > count)            code = ST_BAD_START;
    else if (first_bad)                                     code = ST_FIRST_LEAK;
    else if (two_way && last_nz)                            code = ST_LAST_LEAK;
    else if (zero_seen)                                     code = ST_ZERO_FLUX;
    else                                                    code = ST_OK;

    rev_eff = cmd.init ? cmd.init_rev : rev;
    sidx    = rev_eff ? (count - start_ms) : (start_ms - CNT_W'(1));
    n_m1    = count[ADDR_W-1:0] - ADDR_W'(2);
    orig_i  = ({1'b0, i} == sidx) ? FIX_ONE : '0;
    orig_n  = ({1'b0, n_m1} == sidx) ? FIX_ONE : '0;

    unique case (cmd.psel)
      PS_I1:   k = i + ADDR_W'(1);
      PS_IM1:  k = i - ADDR_W'(1);
      default: k = i;
    endcase
    paddr = chain_addr(rev, k, count);
    taddr = chain_addr(rev, i, count);

    pv   = rev ? (PROB_ONE - prob_q) : prob_q;
    cfp  = fix_t'({{(DATA_W-PROB_W){1'b0}}, pv}) <<< (IFB - PROB_FRAC);
    tval = fix_t'({{(DATA_W-TIME_W){1'b0}}, time_q}) <<< (IFB - TIME_FRAC);

    unique case (cmd.mul_sel)
      MS_FP_FM: begin ma = fp;   mb = fm; end
      MS_FM_PR: begin ma = fm;   mb = pr; end
      MS_FP_X:  begin ma = fp;   mb = x;  end
      MS_TM_X:  begin ma = tval; mb = x;  end
      default:  begin ma = fp;   mb = fm; end
    endcase
    unique case (cmd.div_sel)
      DS_PR_PD: begin da = pr;   db = pd;     end
      DS_T_DG:  begin da = t;    db = diag_q; end
      default:  begin da = mres; db = pd;     end
    endcase

    r_new   = sat_sub(orig_i, qres);
    dg_we   = (cmd.init && count > CNT_W'(1)) || cmd.ld == LD_R;
    dg_addr = cmd.init ? n_m1 : i;
    dg_data = cmd.init ? FIX_MONE : d;
    rh_data = cmd.init ? orig_n : r_new;

    stat.code_ok  = (code == ST_OK);
    stat.n_zero   = (count == CNT_W'(1));
    stat.n_one    = (count == CNT_W'(2));
    stat.i_zero   = (i == '0);
    stat.i_last   = ({1'b0, i} == count - CNT_W'(2));
    stat.two_way  = two_way;
    stat.mul_done = mdone;
    stat.div_done = ddone;
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.store && count != CNT_W'(MAX_MS)) begin
      prob_mem[count[ADDR_W-1:0]] <= p_in;
      time_mem[count[ADDR_W-1:0]] <= mean_time;
    end
    if (dg_we) begin
      diag_mem[dg_addr] <= dg_data;
      rhs_mem[dg_addr]  <= rh_data;
    end
    prob_q <= prob_mem[paddr];
    time_q <= time_mem[taddr];
    diag_q <= diag_mem[i];
    rhs_q  <= rhs_mem[i];
  end

  // chain bookkeeping and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err_ovf   <= 1'b0;
      first_bad <= 1'b0;
      zero_seen <= 1'b0;
      last_nz   <= 1'b0;
      start_ms  <= CNT_W'(1);
      two_way   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_START:   start_ms <= cfg_data;
          CFG_TWO_WAY: two_way  <= cfg_data[0];
        endcase
      end
      if (cmd.publish) begin
        count     <= '0;
        err_ovf   <= 1'b0;
        first_bad <= 1'b0;
        zero_seen <= 1'b0;
        last_nz   <= 1'b0;
      end else if (cmd.store) begin
        if (count == CNT_W'(MAX_MS)) begin
          err_ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
          if (count == '0) begin
            first_bad <= (p_in != PROB_ONE);
          end
          if (last_milestone) begin
            last_nz <= (p_in != '0);
          end else if (p_in == '0) begin
            zero_seen <= 1'b1;
          end
        end
      end
    end
  end

  // solver registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      rev <= cmd.init_rev;
      i   <= (count > CNT_W'(2)) ? count[ADDR_W-1:0] - ADDR_W'(3) : '0;
      pd  <= FIX_MONE;
      pr  <= orig_n;
      sum <= '0;
    end
    unique case (cmd.ld)
      LD_FP:  fp  <= cfp;
      LD_FM:  fm  <= sat_sub(FIX_ONE, cfp);
      LD_D:   d   <= sat_sub(FIX_MONE, qres);
      LD_R: begin
        pd <= d;
        pr <= r_new;
        if (i != '0) begin
          i <= i - ADDR_W'(1);
        end
      end
      LD_X:   x   <= qres;
      LD_ACC: sum <= sat_sub(sum, mres);
      LD_T:   t   <= sat_sub(rhs_q, mres);
      LD_INC: i   <= i + ADDR_W'(1);
      default: ;
    endcase
    if (cmd.begin_solve) begin
      fwd_r <= '0;
      rev_r <= '0;
    end
    if (cmd.save_fwd) begin
      fwd_r <= to_out(sum);
    end
    if (cmd.save_rev) begin
      rev_r <= to_out(sum);
    end
    if (cmd.publish) begin
      forward_mfpt <= fwd_r;
      reverse_mfpt <= rev_r;
      status       <= code;
    end
  end

endmodule

FILE: sv/mfpt_ctrl.sv
// ============================================================================
// mfpt_ctrl
// Controller: loads words, sequences checks, backward elimination and
// forward substitution for each chain, and hands off the result word.
// ============================================================================
module mfpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            last_milestone,
  output logic            out_valid,
  input  logic            out_stall,
  input  mfpt_pkg::stat_t stat,
  output mfpt_pkg::cmd_t  cmd
);
  import mfpt_pkg::*;

  typedef enum logic [30:0] {
    S_IDLE   = 31'h00000001,
    S_CHECK  = 31'h00000002,
    S_INIT   = 31'h00000004,
    S_BK_RD  = 31'h00000008,
    S_BK_FP  = 31'h00000010,
    S_BK_FM  = 31'h00000020,
    S_BK_M1  = 31'h00000040,
    S_BK_M1W = 31'h00000080,
    S_BK_D1  = 31'h00000100,
    S_BK_D1W = 31'h00000200,
    S_BK_M2  = 31'h00000400,
    S_BK_M2W = 31'h00000800,
    S_BK_D2  = 31'h00001000,
    S_BK_D2W = 31'h00002000,
    S_BK_WR  = 31'h00004000,
    S_FW_X0  = 31'h00008000,
    S_FW_X0W = 31'h00010000,
    S_FW_LX  = 31'h00020000,
    S_FW_TM  = 31'h00040000,
    S_FW_TMW = 31'h00080000,
    S_FW_ACC = 31'h00100000,
    S_FW_INC = 31'h00200000,
    S_FW_RD  = 31'h00400000,
    S_FW_FP  = 31'h00800000,
    S_FW_M   = 31'h01000000,
    S_FW_MW  = 31'h02000000,
    S_FW_T   = 31'h04000000,
    S_FW_D   = 31'h08000000,
    S_FW_DW  = 31'h10000000,
    S_END    = 31'h20000000,
    S_PUB    = 31'h40000000
  } state_t;

  state_t state, state_next;
  logic   rev_pass, rev_pass_next;
  logic   out_valid_next;

  always_comb begin
    state_next    = state;
    rev_pass_next = rev_pass;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.store = in_valid;
        if (in_valid && last_milestone) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.begin_solve = 1'b1;
        rev_pass_next   = 1'b0;
        state_next      = stat.code_ok ? S_INIT : S_PUB;
      end
      S_INIT: begin
        cmd.init     = 1'b1;
        cmd.init_rev = rev_pass;
        priority if (stat.n_zero) state_next = S_END;
        else if (stat.n_one)      state_next = S_FW_X0;
        else                      state_next = S_BK_RD;
      end
      S_BK_RD:  state_next = S_BK_FP;
      S_BK_FP: begin
        cmd.ld     = LD_FP;
        cmd.psel   = PS_I1;
        state_next = S_BK_FM;
      end
      S_BK_FM: begin
        cmd.ld     = LD_FM;
        state_next = S_BK_M1;
      end
      S_BK_M1: begin
        cmd.mul_sel = MS_FP_FM;
        state_next  = S_BK_M1W;
      end
      S_BK_M1W: if (stat.mul_done) state_next = S_BK_D1;
      S_BK_D1: begin
        cmd.div_sel = DS_M_PD;
        state_next  = S_BK_D1W;
      end
      S_BK_D1W: if (stat.div_done) state_next = S_BK_M2;
      S_BK_M2: begin
        cmd.ld      = LD_D;
        cmd.mul_sel = MS_FM_PR;
        state_next  = S_BK_M2W;
      end
      S_BK_M2W: if (stat.mul_done) state_next = S_BK_D2;
      S_BK_D2: begin
        cmd.div_sel = DS_M_PD;
        state_next  = S_BK_D2W;
      end
      S_BK_D2W: if (stat.div_done) state_next = S_BK_WR;
      S_BK_WR: begin
        cmd.ld     = LD_R;
        state_next = stat.i_zero ? S_FW_X0 : S_BK_RD;
      end
      S_FW_X0: begin
        cmd.div_sel = DS_PR_PD;
        state_next  = S_FW_X0W;
      end
      S_FW_X0W: if (stat.div_done) state_next = S_FW_LX;
      S_FW_LX: begin
        cmd.ld     = LD_X;
        state_next = S_FW_TM;
      end
      S_FW_TM: begin
        cmd.mul_sel = MS_TM_X;
        state_next  = S_FW_TMW;
      end
      S_FW_TMW: if (stat.mul_done) state_next = S_FW_ACC;
      S_FW_ACC: begin
        cmd.ld     = LD_ACC;
        state_next = stat.i_last ? S_END : S_FW_INC;
      end
      S_FW_INC: begin
        cmd.ld     = LD_INC;
        state_next = S_FW_RD;
      end
      S_FW_RD: begin
        cmd.psel   = PS_IM1;
        state_next = S_FW_FP;
      end
      S_FW_FP: begin
        cmd.ld     = LD_FP;
        state_next = S_FW_M;
      end
      S_FW_M: begin
        cmd.mul_sel = MS_FP_X;
        state_next  = S_FW_MW;
      end
      S_FW_MW: if (stat.mul_done) state_next = S_FW_T;
      S_FW_T: begin
        cmd.ld     = LD_T;
        state_next = S_FW_D;
      end
      S_FW_D: begin
        cmd.div_sel = DS_T_DG;
        state_next  = S_FW_DW;
      end
      S_FW_DW: if (stat.div_done) state_next = S_FW_LX;
      S_END: begin
        if (rev_pass) begin
          cmd.save_rev = 1'b1;
          state_next   = S_PUB;
        end else begin
          cmd.save_fwd = 1'b1;
          if (stat.two_way) begin
            rev_pass_next = 1'b1;
            state_next    = S_INIT;
          end else begin
            state_next = S_PUB;
          end
        end
      end
      S_PUB: begin
        // hold until the previous result word is taken
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rev_pass  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rev_pass  <= rev_pass_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: sv/milestone_mfpt_solver.sv
// ============================================================================
// milestone_mfpt_solver
// Milestoning mean first passage time solver, forward and optional reverse.
// ============================================================================
// Input words are taken one per cycle, one per milestone, until a word with
// last_milestone set; the block then stalls its input and solves. Each chain
// has n = N-1 solved milestones. The radix-2 divider produces one quotient
// per issue (two per eliminated milestone, one per substituted milestone),
// and the four-step multiplier one product per issue. Two-way mode runs a
// second chain of the same length. The result word sits in an output
// register; new input words are loaded while it waits, but the next result is
// handed over only after the previous one is taken.
module milestone_mfpt_solver (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfpt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mfpt_pkg::PROB_W-1:0]          forward_prob,
  input  logic [mfpt_pkg::TIME_W-1:0]          mean_time,
  input  logic                                 last_milestone,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mfpt_pkg::DATA_W-1:0]   forward_mfpt,
  output logic signed [mfpt_pkg::DATA_W-1:0]   reverse_mfpt,
  output logic [mfpt_pkg::STAT_W-1:0]          status
);
  import mfpt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  mfpt_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last_milestone (last_milestone),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .stat           (stat),
    .cmd            (cmd)
  );

  mfpt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .forward_prob   (forward_prob),
    .mean_time      (mean_time),
    .last_milestone (last_milestone),
    .cmd            (cmd),
    .stat           (stat),
    .forward_mfpt   (forward_mfpt),
    .reverse_mfpt   (reverse_mfpt),
    .status         (status)
  );

endmodule

FILE: sv/mfpt_chk.sv
// ============================================================================
// mfpt_chk
// Port-level checks of the milestone MFPT solver, bound to the top level.
// ============================================================================
module mfpt_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                last_milestone,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [mfpt_pkg::DATA_W-1:0]  forward_mfpt,
  input logic signed [mfpt_pkg::DATA_W-1:0]  reverse_mfpt,
  input logic [mfpt_pkg::STAT_W-1:0]         status
);
  import mfpt_pkg::*;

  // stalled result word must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(forward_mfpt) &&
    $stable(reverse_mfpt) && $stable(status))
    else $error("result word changed while stalled");

  // any error reports zero passage times
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> forward_mfpt == '0 && reverse_mfpt == '0)
    else $error("nonzero MFPT with error status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVERFLOW)
    else $error("status code out of range");

  // no result word right after reset
  a_no_spurious: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

  // input holds off once the closing word of a chain is taken
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_milestone |=> in_stall)
    else $error("input not stalled after last milestone word");

endmodule

bind milestone_mfpt_solver mfpt_chk u_mfpt_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .last_milestone (last_milestone),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .forward_mfpt   (forward_mfpt),
  .reverse_mfpt   (reverse_mfpt),
  .status         (status)
);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Milestone MFPT solver testbench
// Sends milestone chains at random idle and stall rates under several register
// settings. Checks each result word field by field against an in-bench
// fixed-point model of the elimination and substitution solve.
// ----------------------------------------------------------------------------
module tb;
  import mfpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PROB_W-1:0] prob;
    logic [TIME_W-1:0] mtime;
    logic              last;
  } ms_word_t;

  typedef struct {
    fix_t    fwd;
    fix_t    rev;
    status_t st;
  } mfpt_word_t;

  localparam fix_t Q_ONE = 64'sh1_0000_0000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [PROB_W-1:0] forward_prob = '0;
  logic [TIME_W-1:0] mean_time = '0;
  logic last_milestone = 0;
  logic out_valid;
  logic out_stall = 0;
  fix_t forward_mfpt, reverse_mfpt;
  logic [STAT_W-1:0] status;

  milestone_mfpt_solver dut (.*);

  always #4 clk = ~clk;

  ms_word_t   chain_q[$];
  mfpt_word_t mfpt_q[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int mismatches = 0, results = 0, ok_results = 0, words_sent = 0;

  // model state
  logic [PROB_W-1:0] m_prob[MAX_MS];
  logic [TIME_W-1:0] m_time[MAX_MS];
  int m_count = 0, m_err = 0;
  int m_start = 1;
  bit m_two = 0;

  function automatic fix_t clip_mag(logic [63:0] m, bit neg);
    if (neg) return (m >= 64'h8000_0000_0000_0000) ? FIX_MIN : fix_t'(-m);
    return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? FIX_MAX : fix_t'(m);
  endfunction

  function automatic logic [63:0] abs64(fix_t v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic fix_t q_sub(fix_t a, fix_t b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    if (d > 65'sh0_7FFF_FFFF_FFFF_FFFF) return FIX_MAX;
    if (d < -65'sh0_8000_0000_0000_0000) return FIX_MIN;
    return d[63:0];
  endfunction

  function automatic fix_t q_mul(fix_t a, fix_t b);
    logic [127:0] p;
    p = ({64'b0, abs64(a)} * {64'b0, abs64(b)}) >> IFB;
    if (p[127:64] != 0) p[63:0] = '1;
    return clip_mag(p[63:0], (a < 0) != (b < 0));
  endfunction

  function automatic fix_t q_div(fix_t a, fix_t b);
    logic [127:0] q;
    if (abs64(a) == 0) return 0;
    if (abs64(b) == 0) return clip_mag('1, (a < 0) != (b < 0));
    q = ({64'b0, abs64(a)} << IFB) / {64'b0, abs64(b)};
    if (q[127:64] != 0) q[63:0] = '1;
    return clip_mag(q[63:0], (a < 0) != (b < 0));
  endfunction

  function automatic fix_t link_prob(int i, int nm, bit rev);
    logic [63:0] p;
    p = rev ? 64'(PROB_ONE) - 64'(m_prob[nm-1-i]) : 64'(m_prob[i]);
    return fix_t'(p << (IFB - PROB_FRAC));
  endfunction

  function automatic fix_t link_time(int i, int nm, bit rev);
    logic [63:0] t;
    t = rev ? 64'(m_time[nm-1-i]) : 64'(m_time[i]);
    return fix_t'(t << (IFB - TIME_FRAC));
  endfunction

  function automatic fix_t passage_time(int nm, int sidx, bit rev);
    fix_t diag[MAX_MS];
    fix_t rhs[MAX_MS];
    fix_t acc, x, fp, fm;
    int n;
    n = nm - 1;
    acc = 0;
    if (n == 0) return 0;
    for (int i = 0; i < n; i++) rhs[i] = (i == sidx) ? Q_ONE : 0;
    diag[n-1] = -Q_ONE;
    for (int i = n - 2; i >= 0; i--) begin
      fp = link_prob(i, nm, rev);
      fm = q_sub(Q_ONE, link_prob(i + 1, nm, rev));
      diag[i] = q_sub(-Q_ONE, q_div(q_mul(fp, fm), diag[i+1]));
      rhs[i] = q_sub(rhs[i], q_div(q_mul(fm, rhs[i+1]), diag[i+1]));
    end
    x = q_div(rhs[0], diag[0]);
    acc = q_sub(acc, q_mul(link_time(0, nm, rev), x));
    for (int i = 1; i < n; i++) begin
      fp = link_prob(i - 1, nm, rev);
      x = q_div(q_sub(rhs[i], q_mul(fp, x)), diag[i]);
      acc = q_sub(acc, q_mul(link_time(i, nm, rev), x));
    end
    return acc;
  endfunction

  function automatic fix_t q_out(fix_t v);
    return clip_mag(abs64(v) >> (IFB - OUT_FRAC), v < 0);
  endfunction

  // take one milestone word; returns 1 when it closes a chain
  function automatic bit load_milestone(ms_word_t w, output mfpt_word_t r);
    logic [PROB_W-1:0] p;
    int nm;
    status_t st;
    p = (w.prob > PROB_ONE) ? PROB_ONE : w.prob;
    if (m_count >= MAX_MS) m_err = ST_OVERFLOW;
    else begin
      m_prob[m_count] = p;
      m_time[m_count] = w.mtime;
      m_count++;
    end
    if (!w.last) return 0;
    nm = m_count;
    st = ST_OK;
    if (m_err != 0) st = status_t'(m_err);
    else if (m_start < 1 || m_start > nm) st = ST_BAD_START;
    else if (m_prob[0] != PROB_ONE) st = ST_FIRST_LEAK;
    else if (m_two && m_prob[nm-1] != 0) st = ST_LAST_LEAK;
    else begin
      for (int i = 0; i + 1 < nm; i++)
        if (m_prob[i] == 0) begin
          st = ST_ZERO_FLUX;
          break;
        end
    end
    r.st = st;
    r.fwd = 0;
    r.rev = 0;
    if (st == ST_OK) begin
      r.fwd = q_out(passage_time(nm, m_start - 1, 0));
      if (m_two) r.rev = q_out(passage_time(nm, nm - m_start, 1));
    end
    m_count = 0;
    m_err = 0;
    return 1;
  endfunction

  // driver: advance when the current word is taken or nothing is offered
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (chain_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1;
        forward_prob <= chain_q[0].prob;
        mean_time <= chain_q[0].mtime;
        last_milestone <= chain_q[0].last;
        chain_q.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= 20000;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    mfpt_word_t r, e;
    ms_word_t w;
    if (!rst && in_valid && !in_stall) begin
      w.prob = forward_prob;
      w.mtime = mean_time;
      w.last = last_milestone;
      words_sent++;
      if (load_milestone(w, r)) mfpt_q.push_back(r);
    end
    if (!rst && out_valid && !out_stall) begin
      results++;
      if (mfpt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word status %0d", status);
      end else begin
        e = mfpt_q.pop_front();
        if (e.st == ST_OK) ok_results++;
        if (forward_mfpt !== e.fwd || reverse_mfpt !== e.rev || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: fwd %0d/%0d rev %0d/%0d status %0d/%0d (exp/act)",
                     e.fwd, forward_mfpt, e.rev, reverse_mfpt, e.st, status);
        end
      end
    end
  end

  function automatic void push_word(int p, logic [TIME_W-1:0] t, int l);
    ms_word_t w;
    w.prob = PROB_W'(p);
    w.mtime = t;
    w.last = (l != 0);
    chain_q.push_back(w);
  endfunction

  // random chain: mostly well-formed with occasional leaks and zero flux; fully random probabilities when noisy
  function automatic int push_chain(int len, bit noisy);
    logic [PROB_W-1:0] p;
    for (int i = 0; i < len; i++) begin
      if (noisy) p = PROB_W'($urandom_range(0, 131071));
      else if (i == 0)
        p = ($urandom_range(19) == 0) ? PROB_W'($urandom_range(0, 131071)) : PROB_ONE;
      else if (i == len - 1) p = $urandom_range(3) != 0 ? '0 : PROB_W'($urandom_range(0, 65536));
      else if ($urandom_range(39) == 0) p = '0;
      else p = PROB_W'($urandom_range(1, 65536));
      push_word(p, $urandom(), i == len - 1);
    end
    return len;
  endfunction

  task automatic drain();
    while (chain_q.size() != 0 || mfpt_q.size() != 0 || in_valid) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_START) m_start = val;
    else m_two = val[0];
  endtask

  initial begin
    int starts[8] = '{1, 2, 3, 5, 64, 1, 0, 4};
    bit twos[8] = '{0, 1, 0, 1, 1, 1, 0, 0};
    int idle_s[4] = '{0, 48, 0, 27};
    int idle_r[4] = '{0, 0, 48, 27};
    int n, len;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: extremes, leaks, zero flux, single milestone, start at end
    write_reg(CFG_TWO_WAY, CFG_DATA_W'(1));
    push_word(PROB_ONE, 32'hFFFF_FFFF, 0);
    push_word(17'h1FFFF, 32'h0, 0);
    push_word(0, 32'hFFFF_FFFF, 1);
    push_word(PROB_ONE, 32'h0001_0000, 0);
    push_word(17'h8000, 32'h0002_0000, 0);
    push_word(17'h4000, 32'h0, 1);
    push_word(17'hFFFF, 32'h1234, 0);
    push_word(0, 32'h1, 1);
    push_word(PROB_ONE, 32'h5, 0);
    push_word(PROB_ONE, 32'h7, 1);
    push_word(PROB_ONE, 32'h8000_0000, 0);
    push_word(0, 32'h9, 0);
    push_word(0, 32'h9, 1);
    push_word(0, 32'h0, 1);
    push_word(PROB_ONE, 32'hFFFF_FFFF, 0);
    push_word(1, 32'hFFFF_FFFF, 0);
    push_word(1, 32'hFFFF_FFFF, 0);
    push_word(0, 32'hFFFF_FFFF, 1);
    drain();
    write_reg(CFG_START, CFG_DATA_W'(3));
    push_word(PROB_ONE, 32'h0001_0000, 0);
    push_word(17'h1_0000, 32'h0003_0000, 0);
    push_word(0, 32'h0, 1);
    push_word(PROB_ONE, 32'h0001_0000, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_START, CFG_DATA_W'(starts[ph]));
      write_reg(CFG_TWO_WAY, twos[ph]);
      send_idle_pct = idle_s[ph % 4];
      recv_stall_pct = idle_r[ph % 4];
      n = 0;
      if (ph == 2) begin
        // receiver holds off while short chains keep coming
        hold_req <= 1;
        @(posedge clk);
        hold_req <= 0;
      end
      if (starts[ph] == 64) begin
        n += push_chain(64, 0);
        n += push_chain(64, 0);
      end
      if (ph == 1 || ph == 5) n += push_chain($urandom_range(65, 70), 1);
      while (n < 186) begin
        if ($urandom_range(9) == 0) len = $urandom_range(1, 4);
        else if ($urandom_range(24) == 0) len = $urandom_range(10, 30);
        else len = $urandom_range(2, 7) + (starts[ph] > 1 && starts[ph] < 64 ?
                                           starts[ph] - 1 : 0);
        n += push_chain(len, $urandom_range(7) == 0);
      end
      drain();
    end

    $display("%0d milestone words, %0d chain results (%0d solved, rest error status)",
             words_sent, results, ok_results);
    $display("register settings: start 0,1..5,64; one-way and two-way; 4 idle mixes");
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mfpt_pkg.sv
sv/mfpt_mul.sv
sv/mfpt_div.sv
sv/mfpt_dp.sv
sv/mfpt_ctrl.sv
sv/milestone_mfpt_solver.sv
sv/mfpt_chk.sv
bench/tb.sv
